// ===== hw/rtl/zrld_pkg.sv =====
// ---------------------------------------------------------------------------
// zrld_pkg
// Shared types and constants for the zero run length decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package zrld_pkg;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 16;
  localparam int RUN_W   = 6;

  // control byte fields
  localparam int unsigned CTRL_PAIR_BIT = 7;
  localparam int unsigned CTRL_ZERO_BIT = 6;
  localparam logic [2:0]  PAIR_ZERO_MASK = 3'h7;
  localparam logic [3:0]  PAIR_LIT_MASK  = 4'hf;
  localparam logic [5:0]  RUN_MASK       = 6'h3f;

  // one request from the front to the back: a literal byte or a zero run
  typedef struct packed {
    logic              is_lit;
    logic [BYTE_W-1:0] data;    // literal value, or zero count in the low bits
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic [COUNT_W-1:0] out_index;
    logic               last_of_run;
    logic               limit_hit;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/zero_run_length_decoder.sv =====
// ---------------------------------------------------------------------------
// zero_run_length_decoder
// Zero run length decoder: compressed byte stream in, decompressed bytes out.
// ---------------------------------------------------------------------------
// Input channel: drive in_byte with push; a byte is taken on a clock edge
// with push high and full low. Result channel: while empty is low the oldest
// result (out_byte, out_index, last_of_run, limit_hit) is on the ports; pop
// takes it. cfg_write with cfg_data sets the output limit (reset 65535);
// write it only while the block is idle.
// A front stage classifies each byte into a literal or zero-run request and
// places it in a QUEUE_DEPTH-entry request queue; the back stage gives one
// output byte per cycle unless the result is held. A literal gives one
// output byte; a control byte with N zeros gives N zero bytes, none when N
// is zero. A taken byte passes the request queue, then the result register.
// The back stage is the rate limit: full rises once the queue holds
// QUEUE_DEPTH requests. A stalled receiver holds the result register, then
// the queue, then full. Reset empties the queue and the result register,
// clears the output count and the stopped flag, and sets the limit to 65535.
// Once the limit is reached, further input is taken and dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module zero_run_length_decoder
  import zrld_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [BYTE_W-1:0]  in_byte,
  output logic                    empty,
  input  wire logic               pop,
  output logic [BYTE_W-1:0]       out_byte,
  output logic [COUNT_W-1:0]      out_index,
  output logic                    last_of_run,
  output logic                    limit_hit,
  input  wire logic               cfg_write,
  input  wire logic [COUNT_W-1:0] cfg_data
);

  logic [COUNT_W-1:0] output_limit;
  logic               q_wr;
  cmd_t               q_wdata;
  logic               q_rd;
  cmd_t               q_rdata;
  logic               q_empty;
  logic               res_valid;
  result_t            res;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= '1;
    end else if (cfg_write) begin
      output_limit <= cfg_data;
    end
  end

  zrld_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_byte (in_byte),
    .q_full  (full),
    .q_wr    (q_wr),
    .q_data  (q_wdata)
  );

  zrld_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  zrld_back u_back (
    .clk       (clk),
    .rst       (rst),
    .limit     (output_limit),
    .cmd_valid (!q_empty),
    .cmd       (q_rdata),
    .cmd_pop   (q_rd),
    .res_pop   (pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign empty       = !res_valid;
  assign out_byte    = res.out_byte;
  assign out_index   = res.out_index;
  assign last_of_run = res.last_of_run;
  assign limit_hit   = res.limit_hit;

endmodule

`default_nettype wire

// ===== hw/rtl/zrld_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// zrld_cmd_fifo
// Short request queue between the front and back of the decoder.
// ---------------------------------------------------------------------------
`default_nettype none

module zrld_cmd_fifo
  import zrld_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire cmd_t wr_data,
  output logic      full,
  input  wire logic rd_en,
  output cmd_t      rd_data,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/zrld_front.sv =====
// ---------------------------------------------------------------------------
// zrld_front
// Accepts stream bytes, tracks pending literals and turns each byte into a
// literal or zero-run request.
// ---------------------------------------------------------------------------
`default_nettype none

module zrld_front
  import zrld_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              q_full,
  output logic                   q_wr,
  output cmd_t                   q_data
);

  logic [RUN_W-1:0] lit_pend;
  logic [RUN_W-1:0] lit_pend_next;
  logic [RUN_W-1:0] zeros;
  logic [RUN_W-1:0] lits;
  logic             take;

  assign take = push && !q_full;

  always_comb begin
    if (in_byte[CTRL_PAIR_BIT]) begin
      zeros = {3'b000, in_byte[6:4] & PAIR_ZERO_MASK};
      lits  = {2'b00, in_byte[3:0] & PAIR_LIT_MASK};
    end else if (in_byte[CTRL_ZERO_BIT]) begin
      zeros = in_byte[5:0] & RUN_MASK;
      lits  = '0;
    end else begin
      zeros = '0;
      lits  = in_byte[5:0] & RUN_MASK;
    end
  end

  always_comb begin
    q_wr          = 1'b0;
    q_data.is_lit = 1'b0;
    q_data.data   = in_byte;
    lit_pend_next = lit_pend;
    if (take) begin
      if (lit_pend != '0) begin
        q_wr          = 1'b1;
        q_data.is_lit = 1'b1;
        lit_pend_next = lit_pend - RUN_W'(1);
      end else begin
        // pass every control back, even an empty one, so the limit is checked
        q_wr          = 1'b1;
        q_data.data   = {2'b00, zeros};
        lit_pend_next = lits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lit_pend <= '0;
    end else begin
      lit_pend <= lit_pend_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/zrld_back.sv =====
// ---------------------------------------------------------------------------
// zrld_back
// Executes requests one output byte per cycle unless the result is held,
// counts output bytes against the limit and holds the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module zrld_back
  import zrld_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [COUNT_W-1:0] limit,
  input  wire logic               cmd_valid,
  input  wire cmd_t               cmd,
  output logic                    cmd_pop,
  input  wire logic               res_pop,
  output logic                    res_valid,
  output result_t                 res
);

  logic               finished;
  logic [COUNT_W-1:0] bw;
  logic [COUNT_W-1:0] bw_inc;
  logic [RUN_W-1:0]   zcnt;
  logic               can_load;
  logic               stop;
  logic               hit;
  logic               last_zero;
  logic               no_out;
  logic               emit;

  assign can_load  = !res_valid || res_pop;
  assign stop      = finished || (bw >= limit);
  assign bw_inc    = bw + COUNT_W'(1);
  assign hit       = (bw_inc >= limit);
  assign last_zero = ((zcnt + RUN_W'(1)) == cmd.data[RUN_W-1:0]);
  assign no_out    = !cmd.is_lit && (cmd.data[RUN_W-1:0] == '0);

  always_comb begin
    emit    = 1'b0;
    cmd_pop = 1'b0;
    if (cmd_valid && can_load) begin
      if (stop || no_out) begin
        cmd_pop = 1'b1;   // drop everything once finished, and empty controls
      end else begin
        emit    = 1'b1;
        cmd_pop = cmd.is_lit || hit || last_zero;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.out_byte    <= cmd.is_lit ? cmd.data : '0;
      res.out_index   <= bw;
      res.last_of_run <= cmd.is_lit || hit || last_zero;
      res.limit_hit   <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      finished  <= 1'b0;
      bw        <= '0;
      zcnt      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd_valid && can_load && (stop || (emit && hit))) begin
        finished <= 1'b1;
      end
      if (emit) begin
        bw   <= bw_inc;
        zcnt <= cmd_pop ? '0 : zcnt + RUN_W'(1);
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_finished_sticky: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("finished flag cleared");

  a_count_advance: assert property (@(posedge clk) disable iff (rst)
    emit |=> (bw == $past(bw_inc)) && res_valid)
    else $error("output count did not advance on emit");

  a_hit_finishes: assert property (@(posedge clk) disable iff (rst)
    (emit && hit) |=> finished && res.limit_hit && res.last_of_run)
    else $error("limit hit did not end the request");

endmodule

`default_nettype wire

// ===== tb/zero_run_length_decoder_tb.sv =====
// ---------------------------------------------------------------------------
// zero_run_length_decoder_tb
// Drives compressed bytes into the decoder under random push and pop gaps
// and checks every decompressed byte against a cycle-free decoder model kept
// here, across several output limits, including one hit in a zero run.
// ---------------------------------------------------------------------------
`default_nettype none

module zero_run_length_decoder_tb;
  import zrld_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [BYTE_W-1:0]  in_byte = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [BYTE_W-1:0]  out_byte;
  logic [COUNT_W-1:0] out_index;
  logic               last_of_run;
  logic               limit_hit;
  logic               cfg_write = 1'b0;
  logic [COUNT_W-1:0] cfg_data = '0;

  // decoder model state
  logic [COUNT_W-1:0] out_limit = 16'hFFFF;
  logic [COUNT_W-1:0] out_count = '0;
  logic [RUN_W-1:0]   lit_left = '0;
  bit                 stopped = 1'b0;

  logic [BYTE_W-1:0]  compressed_q[$];
  result_t            decoded_q[$];

  int  gen_lits = 0;
  int  accepted_cnt = 0;
  int  err_count = 0;
  int  tx_wait = 0;
  int  rx_wait = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;
  bit  hold_rx = 1'b0;

  localparam logic [BYTE_W-1:0] DIRECTED [24] = '{
    8'h00, 8'h80, 8'h40, 8'hFF,
    8'h00, 8'hFF, 8'h80, 8'h40, 8'h55, 8'hAA, 8'h01, 8'h7F,
    8'h3F, 8'hC0, 8'h0F, 8'hF0, 8'h02, 8'h04, 8'h08,
    8'h7F, 8'h01, 8'h80, 8'h90, 8'hC0
  };

  zero_run_length_decoder u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_byte     (in_byte),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .out_index   (out_index),
    .last_of_run (last_of_run),
    .limit_hit   (limit_hit),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [RUN_W-1:0] literals_asked(input logic [BYTE_W-1:0] c);
    if (c[CTRL_PAIR_BIT]) return RUN_W'(c & PAIR_LIT_MASK);
    else if (c[CTRL_ZERO_BIT]) return '0;
    return RUN_W'(c & RUN_MASK);
  endfunction

  function automatic int draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic emit_byte(input logic [BYTE_W-1:0] value, input logic is_last);
    result_t r;
    r.out_byte  = value;
    r.out_index = out_count;
    r.limit_hit = 1'b0;
    out_count   = out_count + 1'b1;
    if (out_count >= out_limit) begin
      r.limit_hit = 1'b1;
      stopped     = 1'b1;
    end
    r.last_of_run = is_last | r.limit_hit;
    decoded_q.push_back(r);
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] c);
    int zeros;
    if (!stopped && out_count >= out_limit) stopped = 1'b1;
    if (stopped) return;
    if (lit_left != 0) begin
      emit_byte(c, 1'b1);
      lit_left = lit_left - 1'b1;
    end else begin
      if (c[CTRL_PAIR_BIT]) zeros = int'((c >> 4) & PAIR_ZERO_MASK);
      else if (c[CTRL_ZERO_BIT]) zeros = int'(c & RUN_MASK);
      else zeros = 0;
      // drop the rest of the run once the limit is hit
      for (int z = 0; z < zeros && !stopped; z++) emit_byte(8'h00, z == zeros - 1);
      lit_left = stopped ? '0 : literals_asked(c);
    end
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    got = {out_byte, out_index, last_of_run, limit_hit};
    if (decoded_q.size() == 0) begin
      err_count++;
      if (err_count <= 10)
        $display("unexpected byte %h at index %0d (last %b, hit %b)",
                 got.out_byte, got.out_index, got.last_of_run, got.limit_hit);
    end else begin
      want = decoded_q.pop_front();
      if (got !== want) begin
        err_count++;
        if (err_count <= 10)
          $display({"mismatch: got byte %h idx %0d last %b hit %b, ",
                    "want byte %h idx %0d last %b hit %b"},
                   got.out_byte, got.out_index, got.last_of_run, got.limit_hit,
                   want.out_byte, want.out_index, want.last_of_run, want.limit_hit);
      end
    end
  endtask

  // mostly control bytes followed by their literals, some raw noise bytes
  task automatic add_stream(input int n);
    logic [BYTE_W-1:0] b;
    int                k;
    int                len;
    repeat (n) begin
      if (gen_lits != 0) begin
        b = BYTE_W'($urandom);
        gen_lits--;
      end else begin
        k   = $urandom_range(0, 9);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
        if (k < 4) b = 8'h80 | BYTE_W'($urandom & 32'h7F);
        else if (k < 6) b = 8'h40 | BYTE_W'(len);
        else if (k < 8) b = BYTE_W'(len);
        else b = BYTE_W'($urandom);
        gen_lits = int'(literals_asked(b));
      end
      compressed_q.push_back(b);
    end
  endtask

  task automatic wait_idle();
    while (compressed_q.size() != 0 || push || decoded_q.size() != 0) @(negedge clk);
    // let requests that give no output drain
    repeat (20) @(negedge clk);
  endtask

  task automatic write_limit(input logic [COUNT_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    out_limit  = value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      tx_wait = 0;
    end else begin
      if (push && !full) begin
        decode_byte(in_byte);
        accepted_cnt++;
        if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
        tx_wait = draw_wait(tx_burst);
      end
      if (!push || !full) begin
        if (tx_wait != 0) begin
          tx_wait--;
          push <= 1'b0;
        end else if (compressed_q.size() != 0) begin
          push    <= 1'b1;
          in_byte <= compressed_q.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_wait = 0;
    end else begin
      if (pop && !empty) begin
        check_result();
        if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
        rx_wait = draw_wait(rx_burst);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      pop <= (rx_wait == 0) && !hold_rx;
    end
  end

  // hold off the receiver long enough to back up the request queue
  initial begin
    wait (accepted_cnt >= 60);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (400) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed bytes under the reset limit
    foreach (DIRECTED[i]) compressed_q.push_back(DIRECTED[i]);
    wait_idle();

    write_limit(16'($urandom_range(40000, 65534)));
    add_stream(175);
    wait_idle();

    write_limit(16'hFFFF);
    add_stream(175);
    while (gen_lits != 0) add_stream(1);
    wait_idle();

    // hit the limit on the third zero of a ten-zero run
    write_limit(out_count + 16'd3);
    compressed_q.push_back(8'h4A);
    add_stream(6);
    wait_idle();

    write_limit(16'd1);
    add_stream(4);
    wait_idle();

    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
